/* rtl/core/smt_pkg.sv */
// Shared types and codes for the sorted multiset table.
package smt_pkg;

  typedef logic signed [31:0] key_t;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DEL_ONE = 2'd1,
    REQ_DEL_ALL = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NO_MATCH = 2'd2,
    STS_BEYOND   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_e;

  typedef struct packed {
    req_e       req_type;
    key_t       key_value;
    logic [3:0] read_position;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] removed_count;
    key_t       read_value;
    logic [4:0] occupancy;
  } rsp_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

/* rtl/core/smt_req_if.sv */
// Request channel: valid/ready handshake carrying one request beat.
interface smt_req_if;
  import smt_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/smt_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result beat.
interface smt_rsp_if;
  import smt_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/smt_cell.sv */
// One storage cell of the sorted chain: entry, valid bit and compare flags.
module smt_cell
  import smt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  key_t       key_i,
  input  key_t       left_entry_i,
  input  logic       left_valid_i,
  input  logic       left_gt_i,
  input  key_t       right_entry_i,
  input  logic       right_valid_i,
  output key_t       entry_o,
  output logic       valid_o,
  output logic       gt_o,
  output logic       eq_o
);

  key_t entry_q, entry_d;
  logic valid_q, valid_d;
  logic gt_q, eq_q, ge_q;
  logic gt_c, eq_c, ge_c;

  // An empty cell counts as greater than any key.
  assign gt_c = !valid_q || ($signed(entry_q) >  $signed(key_i));
  assign ge_c = !valid_q || ($signed(entry_q) >= $signed(key_i));
  assign eq_c = valid_q && (entry_q == key_i);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.ins_en && gt_q) begin
      // First greater cell takes the key, the rest take their left neighbor.
      if (left_gt_i) begin
        entry_d = left_entry_i;
        valid_d = left_valid_i;
      end else begin
        entry_d = key_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.del_en && ge_q) begin
      entry_d = right_entry_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b0;
      ge_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        gt_q <= gt_c;
        eq_q <= eq_c;
        ge_q <= ge_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;

endmodule

/* rtl/core/sorted_multiset_table.sv */
// Sorted multiset table: a chain of compare cells with a request sequencer.
//
//   channel | dir | beat
//   --------+-----+----------------------------------------------------
//   req_i   | in  | req_type, key_value, read_position
//   rsp_o   | out | status, removed_count, read_value, occupancy
//
// Insert, delete one and read: the accept edge latches the compare flags in
// every cell, then the execute state shifts the chain and loads the result
// register. Delete all makes one compare/shift pass of the chain for each
// removed entry. Reset empties the table at once (valid bits and count). A
// result waiting in the output register holds the chain update until it is
// taken; a new request is taken only when idle.
module sorted_multiset_table
  import smt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  smt_req_if.sink    req_i,
  smt_rsp_if.source  rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_e     state_q, state_d;
  req_e       type_q;
  key_t       key_q;
  logic [3:0] pos_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] removed_q, removed_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       out_q, out_d;

  cell_ctrl_t ctrl;
  key_t       cmp_key;
  logic       accept;
  logic       out_free;
  logic       any_match;
  logic       full;
  logic       pos_ok;
  key_t       read_sel;

  logic          fin;
  status_e       fin_status;
  logic [CW-1:0] fin_removed;
  key_t          fin_value;
  logic [CW-1:0] fin_count;

  key_t entry [CAPACITY];
  logic valid [CAPACITY];
  logic gt    [CAPACITY];
  logic eq    [CAPACITY];

  key_t left_entry  [CAPACITY];
  logic left_valid  [CAPACITY];
  logic left_gt     [CAPACITY];
  key_t right_entry [CAPACITY];
  logic right_valid [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_entry[i] = '0;
      assign left_valid[i] = 1'b1;
      assign left_gt[i]    = 1'b0;
    end else begin : g_mid
      assign left_entry[i] = entry[i-1];
      assign left_valid[i] = valid[i-1];
      assign left_gt[i]    = gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry[i] = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner
      assign right_entry[i] = entry[i+1];
      assign right_valid[i] = valid[i+1];
    end

    smt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (cmp_key),
      .left_entry_i  (left_entry[i]),
      .left_valid_i  (left_valid[i]),
      .left_gt_i     (left_gt[i]),
      .right_entry_i (right_entry[i]),
      .right_valid_i (right_valid[i]),
      .entry_o       (entry[i]),
      .valid_o       (valid[i]),
      .gt_o          (gt[i]),
      .eq_o          (eq[i])
    );
  end

  always_comb begin
    any_match = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_match = any_match | eq[i];
    end
  end

  // Ranks reach only the first sixteen cells.
  always_comb begin
    read_sel = '0;
    for (int i = 0; i < CAPACITY && i < 16; i++) begin
      if (int'(pos_q) == i) begin
        read_sel = entry[i];
      end
    end
  end

  assign full     = (count_q == CW'(CAPACITY));
  assign pos_ok   = (int'(pos_q) < int'(count_q));
  assign out_free = !out_valid_q || rsp_o.ready;
  assign accept   = req_i.valid && req_i.ready;
  assign cmp_key  = (state_q == S_IDLE) ? req_i.data.key_value : key_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    ctrl        = '0;
    req_i.ready = (state_q == S_IDLE);
    fin         = 1'b0;
    fin_status  = STS_OK;
    fin_removed = removed_q;
    fin_value   = '0;
    fin_count   = count_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          ctrl.cmp_en = 1'b1;
          removed_d   = '0;
          state_d     = S_EXEC;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (type_q)
            REQ_INSERT: begin
              fin = 1'b1;
              if (full) begin
                fin_status = STS_FULL;
              end else begin
                ctrl.ins_en = 1'b1;
                count_d     = count_q + 1'b1;
                fin_count   = count_q + 1'b1;
              end
            end
            REQ_DEL_ONE, REQ_DEL_ALL: begin
              if (any_match) begin
                ctrl.del_en = 1'b1;
                count_d     = count_q - 1'b1;
                removed_d   = removed_q + 1'b1;
                if (type_q == REQ_DEL_ALL) begin
                  // Go around for the next equal entry.
                  state_d = S_CMP;
                end else begin
                  fin         = 1'b1;
                  fin_removed = removed_q + 1'b1;
                  fin_count   = count_q - 1'b1;
                end
              end else begin
                fin        = 1'b1;
                fin_status = (removed_q == '0) ? STS_NO_MATCH : STS_OK;
              end
            end
            REQ_READ: begin
              fin = 1'b1;
              if (pos_ok) begin
                fin_value = read_sel;
              end else begin
                fin_status = STS_BEYOND;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_d         = 1'b1;
      out_d.status        = fin_status;
      out_d.removed_count = 5'(fin_removed);
      out_d.read_value    = fin_value;
      out_d.occupancy     = 5'(fin_count);
      state_d             = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      type_q <= req_i.data.req_type;
      key_q  <= req_i.data.key_value;
      pos_q  <= req_i.data.read_position;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule
